FILE: rtl/sbws_pkg.sv
// ----------------------------------------------------------------------------
// sbws_pkg
// Shared types and constants for the bristle wear stepper.
// ----------------------------------------------------------------------------
package sbws_pkg;

  localparam int BRISTLE_CNT = 32;
  localparam int HALF_BRISTLES = BRISTLE_CNT / 2;
  localparam int NUM_DRAWS = 2 * HALF_BRISTLES;
  localparam int IDX_W = $clog2(BRISTLE_CNT);
  localparam int HALF_SHIFT = $clog2(HALF_BRISTLES);

  localparam int OP_W = 2;
  localparam int SEED_W = 32;
  localparam int LCG_W = 32;
  localparam int CHANCE_W = 16;
  localparam int LEVEL_W = 8;
  localparam int OUT_IDX_W = 5;
  localparam int NUM_W = CHANCE_W + IDX_W + 1;

  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 4;

  localparam logic [LCG_W-1:0] LCG_MUL = 32'd1103515245;
  localparam logic [LCG_W-1:0] LCG_ADD = 32'd12345;

  localparam logic [LEVEL_W-1:0] LEVEL_MAX = '1;

  localparam logic [CHANCE_W-1:0] RST_OUTER_WEAKEN = 16'd4000;
  localparam logic [CHANCE_W-1:0] RST_INNER_WEAKEN = 16'd0;
  localparam logic [CHANCE_W-1:0] RST_OUTER_STRENGTHEN = 16'd0;
  localparam logic [CHANCE_W-1:0] RST_INNER_STRENGTHEN = 16'd3680;

  typedef enum logic [OP_W-1:0] {
    OP_ADVANCE = 2'd0,
    OP_REFILL  = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    REG_OUTER_WEAKEN     = 2'd0,
    REG_INNER_WEAKEN     = 2'd1,
    REG_OUTER_STRENGTHEN = 2'd2,
    REG_INNER_STRENGTHEN = 2'd3
  } reg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DRAW,
    S_UPD,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [CHANCE_W-1:0] outer_weaken;
    logic [CHANCE_W-1:0] inner_weaken;
    logic [CHANCE_W-1:0] outer_strengthen;
    logic [CHANCE_W-1:0] inner_strengthen;
  } chance_t;

  typedef struct packed {
    logic start;
    logic clr_lvl;
    logic ld_seed;
    logic draw;
    logic upd;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic last_draw;
    logic last_emit;
    logic out_free;
  } sts_t;

endpackage

FILE: rtl/sbws_ctrl.sv
// ----------------------------------------------------------------------------
// sbws_ctrl
// Sequencer: accepts a transaction, steps draws and level updates for an
// advance, then drives result emission for every operation.
// ----------------------------------------------------------------------------
module sbws_ctrl (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [sbws_pkg::OP_W-1:0]      operation_i,
  input  sbws_pkg::sts_t                 sts_i,
  output sbws_pkg::cmd_t                 cmd_o
);

  sbws_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sbws_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sbws_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          case (sbws_pkg::op_e'(operation_i))
            sbws_pkg::OP_ADVANCE: begin
              state_d = sbws_pkg::S_DRAW;
            end
            sbws_pkg::OP_REFILL: begin
              cmd_o.clr_lvl = 1'b1;
              state_d       = sbws_pkg::S_EMIT;
            end
            sbws_pkg::OP_RESTART: begin
              cmd_o.clr_lvl = 1'b1;
              cmd_o.ld_seed = 1'b1;
              state_d       = sbws_pkg::S_EMIT;
            end
            default: begin
              // unused code: state untouched, levels still reported
              state_d = sbws_pkg::S_EMIT;
            end
          endcase
        end
      end
      sbws_pkg::S_DRAW: begin
        cmd_o.draw = 1'b1;
        state_d    = sbws_pkg::S_UPD;
      end
      sbws_pkg::S_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.last_draw ? sbws_pkg::S_EMIT : sbws_pkg::S_DRAW;
      end
      sbws_pkg::S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last_emit) begin
            state_d = sbws_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_d = sbws_pkg::S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/sbws_dp.sv
// ----------------------------------------------------------------------------
// sbws_dp
// Datapath: generator, threshold stage, wear level bank with one
// read-modify-write port, and the result register.
// ----------------------------------------------------------------------------
module sbws_dp (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  sbws_pkg::cmd_t                    cmd_i,
  output sbws_pkg::sts_t                    sts_o,
  input  sbws_pkg::chance_t                 chance_i,
  input  logic [sbws_pkg::SEED_W-1:0]       seed_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [sbws_pkg::OUT_IDX_W-1:0]    out_idx_o,
  output logic [sbws_pkg::LEVEL_W-1:0]      out_lvl_o,
  output logic                              out_last_o
);

  localparam int IW = sbws_pkg::IDX_W;
  localparam int NW = sbws_pkg::NUM_W;
  localparam int CW = sbws_pkg::CHANCE_W;
  localparam int LW = sbws_pkg::LEVEL_W;

  logic [IW-1:0]                 cnt_q, cnt_d;
  logic [sbws_pkg::LCG_W-1:0]    lcg_q, lcg_d;
  logic [CW-1:0]                 weak_q, weak_d;
  logic [CW-1:0]                 strg_q, strg_d;
  logic [LW-1:0]                 lvl_q [sbws_pkg::BRISTLE_CNT];
  logic                          out_valid_q;
  logic [sbws_pkg::OUT_IDX_W-1:0] out_idx_q;
  logic [LW-1:0]                 out_lvl_q;
  logic                          out_last_q;

  logic [IW-1:0]                 pair;
  logic [IW-1:0]                 di;
  logic [IW-1:0]                 upd_idx;
  logic [IW-1:0]                 rd_idx;
  logic [NW-1:0]                 weak_num;
  logic [NW-1:0]                 strg_num;
  logic [CW-1:0]                 rnd;
  logic [CW:0]                   both;
  logic [LW-1:0]                 rd_lvl;
  logic [LW-1:0]                 new_lvl;
  logic                          last_draw;
  logic                          last_emit;

  assign pair      = cnt_q >> 1;
  assign di        = IW'(sbws_pkg::HALF_BRISTLES) - pair;
  assign upd_idx   = cnt_q[0] ? (IW'(sbws_pkg::BRISTLE_CNT - 1) - pair) : pair;
  assign rd_idx    = cmd_i.upd ? upd_idx : cnt_q;
  assign rd_lvl    = lvl_q[rd_idx];
  assign last_draw = (cnt_q == IW'(sbws_pkg::NUM_DRAWS - 1));
  assign last_emit = (cnt_q == IW'(sbws_pkg::BRISTLE_CNT - 1));

  assign sts_o.last_draw = last_draw;
  assign sts_o.last_emit = last_emit;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  // thresholds for the current pair: weight blend over distance from center
  assign weak_num = NW'(di) * NW'(chance_i.outer_weaken)
                  + NW'(pair) * NW'(chance_i.inner_weaken);
  assign strg_num = NW'(di) * NW'(chance_i.outer_strengthen)
                  + NW'(pair) * NW'(chance_i.inner_strengthen);
  assign weak_d   = CW'(weak_num >> sbws_pkg::HALF_SHIFT);
  assign strg_d   = CW'(strg_num >> sbws_pkg::HALF_SHIFT);

  assign lcg_d = sbws_pkg::LCG_W'(lcg_q * sbws_pkg::LCG_MUL + sbws_pkg::LCG_ADD);

  assign rnd  = lcg_q[sbws_pkg::LCG_W-1 -: CW];
  assign both = {1'b0, weak_q} + {1'b0, strg_q};

  always_comb begin
    new_lvl = rd_lvl;
    if (rnd <= weak_q) begin
      if (rd_lvl != sbws_pkg::LEVEL_MAX) begin
        new_lvl = rd_lvl + LW'(1);
      end
    end else if ({1'b0, rnd} <= both) begin
      if (rd_lvl != '0) begin
        new_lvl = rd_lvl - LW'(1);
      end
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.start) begin
      cnt_d = '0;
    end else if (cmd_i.upd) begin
      cnt_d = last_draw ? '0 : cnt_q + IW'(1);
    end else if (cmd_i.emit) begin
      cnt_d = last_emit ? '0 : cnt_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      lcg_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < sbws_pkg::BRISTLE_CNT; k++) begin
        lvl_q[k] <= '0;
      end
    end else begin
      cnt_q <= cnt_d;
      if (cmd_i.ld_seed) begin
        lcg_q <= seed_i;
      end else if (cmd_i.draw) begin
        lcg_q <= lcg_d;
      end
      if (cmd_i.clr_lvl) begin
        for (int k = 0; k < sbws_pkg::BRISTLE_CNT; k++) begin
          lvl_q[k] <= '0;
        end
      end else if (cmd_i.upd) begin
        lvl_q[upd_idx] <= new_lvl;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.draw) begin
      weak_q <= weak_d;
      strg_q <= strg_d;
    end
    if (cmd_i.emit) begin
      out_idx_q  <= sbws_pkg::OUT_IDX_W'(cnt_q);
      out_lvl_q  <= rd_lvl;
      out_last_q <= last_emit;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_idx_o   = out_idx_q;
  assign out_lvl_o   = out_lvl_q;
  assign out_last_o  = out_last_q;

  a_seed_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.ld_seed |=> lcg_q == $past(seed_i))
    else $error("generator did not take seed");

  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clr_lvl |=> lvl_q[0] == '0 && lvl_q[sbws_pkg::BRISTLE_CNT-1] == '0)
    else $error("levels not cleared");

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_last_q |-> out_idx_q == sbws_pkg::OUT_IDX_W'(sbws_pkg::BRISTLE_CNT - 1))
    else $error("last flag on wrong bristle");

  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || out_ready_i)
    else $error("result register overwritten");

endmodule

FILE: rtl/stochastic_bristle_wear_stepper.sv
// ----------------------------------------------------------------------------
// stochastic_bristle_wear_stepper
// Bristle wear stepper with LCG-driven wear updates and an APB register file.
// ----------------------------------------------------------------------------
// Advance: accept, then per draw an LCG multiply step and a read-modify-write
//   of one level, then results; no new item until the last one is emitted.
// Refill / restart / unused op: accept, then results only, bounded by the one
//   result register draining one bristle per cycle unless the output stalls.
// Reset: generator 0, all levels 0, chance registers to defaults; no
//   clearing pass, input can be taken straight out of reset.
// ----------------------------------------------------------------------------
module stochastic_bristle_wear_stepper (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [sbws_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [sbws_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [sbws_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sbws_pkg::OP_W-1:0]            operation_i,
  input  logic [sbws_pkg::SEED_W-1:0]          seed_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [sbws_pkg::OUT_IDX_W-1:0]       bristle_index_o,
  output logic [sbws_pkg::LEVEL_W-1:0]         bristle_level_o,
  output logic                                 last_o
);

  sbws_pkg::chance_t chance_q;
  sbws_pkg::cmd_t    cmd;
  sbws_pkg::sts_t    sts;
  sbws_pkg::reg_e    reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = sbws_pkg::reg_e'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chance_q.outer_weaken     <= sbws_pkg::RST_OUTER_WEAKEN;
      chance_q.inner_weaken     <= sbws_pkg::RST_INNER_WEAKEN;
      chance_q.outer_strengthen <= sbws_pkg::RST_OUTER_STRENGTHEN;
      chance_q.inner_strengthen <= sbws_pkg::RST_INNER_STRENGTHEN;
    end else if (wr_en) begin
      case (reg_sel)
        sbws_pkg::REG_OUTER_WEAKEN: begin
          chance_q.outer_weaken <= pwdata[sbws_pkg::CHANCE_W-1:0];
        end
        sbws_pkg::REG_INNER_WEAKEN: begin
          chance_q.inner_weaken <= pwdata[sbws_pkg::CHANCE_W-1:0];
        end
        sbws_pkg::REG_OUTER_STRENGTHEN: begin
          chance_q.outer_strengthen <= pwdata[sbws_pkg::CHANCE_W-1:0];
        end
        sbws_pkg::REG_INNER_STRENGTHEN: begin
          chance_q.inner_strengthen <= pwdata[sbws_pkg::CHANCE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sbws_pkg::REG_OUTER_WEAKEN: begin
        prdata = sbws_pkg::APB_DATA_W'(chance_q.outer_weaken);
      end
      sbws_pkg::REG_INNER_WEAKEN: begin
        prdata = sbws_pkg::APB_DATA_W'(chance_q.inner_weaken);
      end
      sbws_pkg::REG_OUTER_STRENGTHEN: begin
        prdata = sbws_pkg::APB_DATA_W'(chance_q.outer_strengthen);
      end
      sbws_pkg::REG_INNER_STRENGTHEN: begin
        prdata = sbws_pkg::APB_DATA_W'(chance_q.inner_strengthen);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  sbws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  sbws_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .chance_i    (chance_q),
    .seed_i      (seed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_idx_o   (bristle_index_o),
    .out_lvl_o   (bristle_level_o),
    .out_last_o  (last_o)
  );

endmodule

FILE: tb/stochastic_bristle_wear_stepper_tb.sv
// ----------------------------------------------------------------------------
// stochastic_bristle_wear_stepper_tb
// Drives advance / refill / restart / spare-code transactions into the wear
// stepper, predicts every emitted bristle level with a local generator and
// level store, and checks each result transaction in order. Runs through
// several chance-register settings, including the all-zero and all-ones ones,
// with a long saturating run, random idles on both sides and one long
// receiver hold-off.
// ----------------------------------------------------------------------------
module stochastic_bristle_wear_stepper_tb;
  import sbws_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned IDLE_PCT = 31;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 100;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SEED_W-1:0] seed;
  } stim_item_t;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] idx;
    logic [LEVEL_W-1:0]   level;
    logic                 last;
  } bristle_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [APB_ADDR_W-1:0] paddr = '0;
  logic [APB_DATA_W-1:0] pwdata = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  logic                  in_valid_i = 1'b0;
  logic                  in_ready_o;
  logic [OP_W-1:0]       operation_i = '0;
  logic [SEED_W-1:0]     seed_i = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  logic [OUT_IDX_W-1:0]  bristle_index_o;
  logic [LEVEL_W-1:0]    bristle_level_o;
  logic                  last_o;

  stochastic_bristle_wear_stepper uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .seed_i          (seed_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .bristle_index_o (bristle_index_o),
    .bristle_level_o (bristle_level_o),
    .last_o          (last_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Local copy of the block state
  chance_t             chances = {RST_OUTER_WEAKEN, RST_INNER_WEAKEN,
                                  RST_OUTER_STRENGTHEN, RST_INNER_STRENGTHEN};
  logic [LCG_W-1:0]    wear_rng = '0;
  logic [LEVEL_W-1:0]  wear_lvl [BRISTLE_CNT];

  stim_item_t          pending_items [$];
  bristle_report_t     expected_levels [$];

  int unsigned         mismatch_count = 0;
  int unsigned         readback_errors = 0;
  int unsigned         cycle_count = 0;
  int unsigned         hold_cnt = 0;
  bit                  hold_req = 1'b0;
  bit                  hold_done = 1'b0;
  bit                  calm = 1'b0;

  initial begin
    for (int k = 0; k < BRISTLE_CNT; k++) wear_lvl[k] = '0;
  end

  function automatic logic [CHANCE_W-1:0] next_draw();
    wear_rng = wear_rng * LCG_MUL + LCG_ADD;
    return wear_rng[LCG_W-1:LCG_W-CHANCE_W];
  endfunction

  function automatic void wear_bristle(int k, logic [CHANCE_W-1:0] rnd,
                                       logic [31:0] weaken, logic [31:0] strengthen);
    if ({16'd0, rnd} <= weaken) begin
      if (wear_lvl[k] != LEVEL_MAX) wear_lvl[k] = wear_lvl[k] + LEVEL_W'(1);
    end else if ({16'd0, rnd} <= weaken + strengthen) begin
      if (wear_lvl[k] != '0) wear_lvl[k] = wear_lvl[k] - LEVEL_W'(1);
    end
  endfunction

  function automatic void predict_transaction(logic [OP_W-1:0] op, logic [SEED_W-1:0] seed);
    longint unsigned di;
    longint unsigned id;
    logic [31:0]     weaken;
    logic [31:0]     strengthen;
    logic [CHANCE_W-1:0] ra;
    logic [CHANCE_W-1:0] rb;
    bristle_report_t rep;
    case (op)
      OP_ADVANCE: begin
        // mirrored pairs, thresholds blend outer->inner by distance to center
        for (int i = 0; i < HALF_BRISTLES; i++) begin
          di = 64'(HALF_BRISTLES - i);
          id = 64'(i);
          ra = next_draw();
          rb = next_draw();
          weaken = 32'(((di * chances.outer_weaken + id * chances.inner_weaken) * 2)
                       / BRISTLE_CNT);
          strengthen = 32'(((di * chances.outer_strengthen
                             + id * chances.inner_strengthen) * 2) / BRISTLE_CNT);
          wear_bristle(i, ra, weaken, strengthen);
          wear_bristle(BRISTLE_CNT - 1 - i, rb, weaken, strengthen);
        end
      end
      OP_REFILL: begin
        for (int k = 0; k < BRISTLE_CNT; k++) wear_lvl[k] = '0;
      end
      OP_RESTART: begin
        for (int k = 0; k < BRISTLE_CNT; k++) wear_lvl[k] = '0;
        wear_rng = seed;
      end
      default: ;
    endcase
    for (int k = 0; k < BRISTLE_CNT; k++) begin
      rep.idx = k[OUT_IDX_W-1:0];
      rep.level = wear_lvl[k];
      rep.last = (k == BRISTLE_CNT - 1);
      expected_levels.push_back(rep);
    end
  endfunction

  // Input driver
  always @(posedge clk_i) begin : drive
    stim_item_t item;
    bit         accepted;
    if (rst_ni) begin
      accepted = in_valid_i && (in_ready_o === 1'b1);
      if (accepted) predict_transaction(operation_i, seed_i);
      if (in_valid_i && !accepted) begin
        // keep offering the same transaction
      end else if (pending_items.size() != 0 &&
                   (calm || $urandom_range(99) >= IDLE_PCT)) begin
        item = pending_items.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= item.op;
        seed_i <= item.seed;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, armed once by the stimulus
  always @(posedge clk_i) begin
    if (hold_cnt != 0) begin
      hold_cnt <= hold_cnt - 1;
    end else if (hold_req && !hold_done) begin
      hold_cnt <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // Result monitor
  always @(posedge clk_i) begin : watch
    bristle_report_t want;
    if (rst_ni) begin
      if (out_valid_o === 1'b1 && out_ready_i) begin
        if (expected_levels.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected result: idx %0d level %0d last %0b",
                     bristle_index_o, bristle_level_o, last_o);
        end else begin
          want = expected_levels.pop_front();
          if (bristle_index_o !== want.idx || bristle_level_o !== want.level ||
              last_o !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("mismatch: exp idx %0d level %0d last %0b, got idx %0d level %0d last %0b",
                       want.idx, want.level, want.last,
                       bristle_index_o, bristle_level_o, last_o);
          end
        end
      end
      out_ready_i <= (hold_cnt != 0) ? 1'b0 : (calm || $urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic reg_write(input reg_e r, input logic [CHANCE_W-1:0] value);
    logic [APB_DATA_W-1:0] word;
    word = {16'($urandom_range(16'hFFFF)), value};  // upper bits are don't-care
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {r, 2'b00};
    pwdata <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    pwrite <= 1'b0;
    penable <= 1'b0;
    case (r)
      REG_OUTER_WEAKEN:     chances.outer_weaken = value;
      REG_INNER_WEAKEN:     chances.inner_weaken = value;
      REG_OUTER_STRENGTHEN: chances.outer_strengthen = value;
      REG_INNER_STRENGTHEN: chances.inner_strengthen = value;
      default: ;
    endcase
    // read back
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata[CHANCE_W-1:0] !== value) begin
      readback_errors++;
      $display("register %0d read back %h, wrote %h", r, prdata[CHANCE_W-1:0], value);
    end
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_chances(input logic [CHANCE_W-1:0] ow, input logic [CHANCE_W-1:0] iw,
                             input logic [CHANCE_W-1:0] os, input logic [CHANCE_W-1:0] is);
    reg_write(REG_OUTER_WEAKEN, ow);
    reg_write(REG_INNER_WEAKEN, iw);
    reg_write(REG_OUTER_STRENGTHEN, os);
    reg_write(REG_INNER_STRENGTHEN, is);
  endtask

  function automatic void queue_item(logic [OP_W-1:0] op, logic [SEED_W-1:0] seed);
    stim_item_t item;
    item.op = op;
    item.seed = seed;
    pending_items.push_back(item);
  endfunction

  function automatic void queue_random(int n);
    int unsigned pick;
    logic [OP_W-1:0] op;
    for (int j = 0; j < n; j++) begin
      pick = $urandom_range(99);
      if (pick < 70) op = OP_ADVANCE;
      else if (pick < 80) op = OP_REFILL;
      else if (pick < 92) op = OP_RESTART;
      else op = OP_SPARE;
      queue_item(op, $urandom);
    end
  endfunction

  // Wait until every transaction is through and all results are in
  task automatic drain();
    do @(negedge clk_i);
    while (pending_items.size() != 0 || in_valid_i || expected_levels.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed, reset chances
    @(negedge clk_i);
    queue_item(OP_ADVANCE, $urandom);
    repeat (3) queue_item(OP_ADVANCE, '0);
    queue_item(OP_SPARE, $urandom);
    queue_item(OP_RESTART, '0);
    repeat (2) queue_item(OP_ADVANCE, '1);
    queue_item(OP_RESTART, '1);
    repeat (4) queue_item(OP_ADVANCE, $urandom);
    queue_item(OP_REFILL, '1);
    repeat (2) queue_item(OP_ADVANCE, $urandom);
    queue_item(OP_RESTART, 32'h5555AAAA);
    repeat (3) queue_item(OP_ADVANCE, $urandom);
    queue_item(OP_SPARE, '1);
    queue_item(OP_ADVANCE, $urandom);
    drain();

    // every draw increments: run the levels into saturation
    set_chances('1, '1, '1, '1);
    @(negedge clk_i);
    queue_item(OP_RESTART, $urandom);
    repeat (258) queue_item(OP_ADVANCE, $urandom);
    queue_item(OP_SPARE, $urandom);
    queue_item(OP_ADVANCE, $urandom);
    drain();

    set_chances('0, '0, '0, '0);
    @(negedge clk_i);
    hold_req = 1'b1;
    queue_random(40);
    drain();

    set_chances(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    @(negedge clk_i);
    calm = 1'b1;
    queue_random(45);
    drain();
    calm = 1'b0;

    set_chances('1, '0, '0, '1);
    @(negedge clk_i);
    queue_random(45);
    drain();

    set_chances(16'($urandom_range(8000)), 16'($urandom_range(8000)),
                16'($urandom_range(8000)), 16'($urandom_range(8000)));
    @(negedge clk_i);
    queue_random(45);
    drain();

    set_chances(RST_OUTER_WEAKEN, RST_INNER_WEAKEN, RST_OUTER_STRENGTHEN,
                RST_INNER_STRENGTHEN);
    @(negedge clk_i);
    queue_random(40);
    drain();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && readback_errors == 0 && expected_levels.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/sbws_pkg.sv
rtl/sbws_ctrl.sv
rtl/sbws_dp.sv
rtl/stochastic_bristle_wear_stepper.sv
tb/stochastic_bristle_wear_stepper_tb.sv
